/* sv/hra_pkg.sv */
// hra_pkg: shared types, register indexes, reset constants and the clamped step function
// for the hold-repeat value adjuster; no dependencies
`timescale 1ns / 1ps

package hra_pkg;

  localparam int unsigned ValueW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic                RstHotkeys    = 1'b1;
  localparam logic                RstContinuous = 1'b1;
  localparam logic [ValueW-1:0]   RstDelay      = 16'd400;
  localparam logic [ValueW-1:0]   RstInterval   = 16'd50;
  localparam logic [ValueW-1:0]   RstStep       = 16'd256;
  localparam logic [ValueW-1:0]   RstMin        = 16'd5120;
  localparam logic [ValueW-1:0]   RstMax        = 16'd38400;
  localparam logic [ValueW-1:0]   RstDefault    = 16'd23040;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HOTKEYS_ENABLED    = 3'd0,
    REG_CONTINUOUS_REPEAT  = 3'd1,
    REG_REPEAT_DELAY_MS    = 3'd2,
    REG_REPEAT_INTERVAL_MS = 3'd3,
    REG_STEP_SIZE          = 3'd4,
    REG_MIN_VALUE          = 3'd5,
    REG_MAX_VALUE          = 3'd6,
    REG_DEFAULT_VALUE      = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic              toggle_pressed;
    logic              up_pressed;
    logic              down_pressed;
    logic              reset_pressed;
    logic [TimeW-1:0]  now_ms;
  } in_req_t;

  typedef struct packed {
    logic [ValueW-1:0] value_out;
    logic              active;
    logic              save_strobe;
  } out_rsp_t;

  typedef struct packed {
    logic              hotkeys_enabled;
    logic              continuous_repeat;
    logic [ValueW-1:0] repeat_delay_ms;
    logic [ValueW-1:0] repeat_interval_ms;
    logic [ValueW-1:0] step_size;
    logic [ValueW-1:0] min_value;
    logic [ValueW-1:0] max_value;
    logic [ValueW-1:0] default_value;
  } cfg_t;

  // add or subtract one step, then clamp: above max gives max, else below min gives min
  function automatic logic [ValueW-1:0] clamp_step(
    input logic [ValueW-1:0] value,
    input logic [ValueW-1:0] step,
    input logic              upward,
    input logic [ValueW-1:0] lo,
    input logic [ValueW-1:0] hi
  );
    logic signed [ValueW+1:0] sum;
    logic signed [ValueW+1:0] lo_s;
    logic signed [ValueW+1:0] hi_s;
    logic [ValueW-1:0]        res;
    sum  = upward ? $signed({2'b00, value}) + $signed({2'b00, step})
                  : $signed({2'b00, value}) - $signed({2'b00, step});
    lo_s = $signed({2'b00, lo});
    hi_s = $signed({2'b00, hi});
    if (sum > hi_s) begin
      res = hi;
    end else if (sum < lo_s) begin
      res = lo;
    end else begin
      res = sum[ValueW-1:0];
    end
    return res;
  endfunction

endpackage

/* sv/hra_cfg.sv */
// hra_cfg: configuration register file with write-only port
// depends on hra_pkg
`timescale 1ns / 1ps

module hra_cfg import hra_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hotkeys_enabled    <= RstHotkeys;
      cfg_q.continuous_repeat  <= RstContinuous;
      cfg_q.repeat_delay_ms    <= RstDelay;
      cfg_q.repeat_interval_ms <= RstInterval;
      cfg_q.step_size          <= RstStep;
      cfg_q.min_value          <= RstMin;
      cfg_q.max_value          <= RstMax;
      cfg_q.default_value      <= RstDefault;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_HOTKEYS_ENABLED:    cfg_q.hotkeys_enabled    <= cfg_wdata_i[0];
        REG_CONTINUOUS_REPEAT:  cfg_q.continuous_repeat  <= cfg_wdata_i[0];
        REG_REPEAT_DELAY_MS:    cfg_q.repeat_delay_ms    <= cfg_wdata_i[ValueW-1:0];
        REG_REPEAT_INTERVAL_MS: cfg_q.repeat_interval_ms <= cfg_wdata_i[ValueW-1:0];
        REG_STEP_SIZE:          cfg_q.step_size          <= cfg_wdata_i[ValueW-1:0];
        REG_MIN_VALUE:          cfg_q.min_value          <= cfg_wdata_i[ValueW-1:0];
        REG_MAX_VALUE:          cfg_q.max_value          <= cfg_wdata_i[ValueW-1:0];
        REG_DEFAULT_VALUE:      cfg_q.default_value      <= cfg_wdata_i[ValueW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/hra_btn.sv */
// hra_btn: one step button with hold timer and auto-repeat, owns its held flag and timestamps
// depends on hra_pkg
`timescale 1ns / 1ps

module hra_btn import hra_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              upward_i,
  input  logic              pressed_i,
  input  logic [TimeW-1:0]  now_ms_i,
  input  cfg_t              cfg_i,
  input  logic [ValueW-1:0] value_i,
  output logic [ValueW-1:0] value_o,
  output logic              release_o
);

  logic             held_q;
  logic [TimeW-1:0] press_t_q;
  logic [TimeW-1:0] last_t_q;
  logic [TimeW-1:0] since_press;
  logic [TimeW-1:0] since_last;
  logic             repeat_due;
  logic             step_now;

  // elapsed times wrap mod 2^32
  assign since_press = now_ms_i - press_t_q;
  assign since_last  = now_ms_i - last_t_q;
  assign repeat_due  = cfg_i.continuous_repeat
                     && (since_press >= {{(TimeW-ValueW){1'b0}}, cfg_i.repeat_delay_ms})
                     && (since_last  >= {{(TimeW-ValueW){1'b0}}, cfg_i.repeat_interval_ms});
  assign step_now    = pressed_i && (!held_q || repeat_due);

  assign value_o   = step_now ? clamp_step(value_i, cfg_i.step_size, upward_i,
                                           cfg_i.min_value, cfg_i.max_value)
                              : value_i;
  assign release_o = !pressed_i && held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= 1'b0;
      press_t_q <= '0;
      last_t_q  <= '0;
    end else if (en_i) begin
      held_q <= pressed_i;
      if (pressed_i && !held_q) begin
        press_t_q <= now_ms_i;
      end
      if (step_now) begin
        last_t_q <= now_ms_i;
      end
    end
  end

endmodule

/* sv/hold_repeat_value_adjuster_top.sv */
// hold_repeat_value_adjuster_top: hold-to-repeat up/down value adjuster; depends on hra_pkg, hra_cfg, hra_btn
// flow: an accepted request is held in the input register and processed into the result
//   register once that register is empty or being taken
// throughput: one request per cycle; the input stalls only while the input register is full
//   and the result is stalled
// reset: asynchronous active low; active flag set, edge detectors and held flags cleared, value and configuration registers take their reset values
`timescale 1ns / 1ps

module hold_repeat_value_adjuster_top import hra_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_req_t             in_req_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_rsp_t            out_rsp_o,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t cfg;

  hra_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // ---------------- input register ----------------
  logic    in_valid_q;
  in_req_t in_q;
  logic    fire;       // request in the input register is processed this cycle
  logic    in_accept;

  // the result register frees up when it is empty or being taken
  assign fire       = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_req_i;
    end
  end

  // ---------------- per-request step logic ----------------
  logic              active_q;
  logic              toggle_prev_q;
  logic              reset_prev_q;
  logic [ValueW-1:0] target_q;

  logic              active_d;
  logic              run;        // request fires, hotkeys on and adjuster active after the toggle
  logic              rst_edge;
  logic [ValueW-1:0] val_rst;
  logic [ValueW-1:0] val_up;
  logic [ValueW-1:0] val_dn;
  logic              rel_up;
  logic              rel_dn;
  logic [ValueW-1:0] target_d;
  logic              save;

  // toggle edge flips the active flag, only with hotkeys on
  assign active_d = cfg.hotkeys_enabled ? (active_q ^ (in_q.toggle_pressed && !toggle_prev_q))
                                        : active_q;
  assign run      = fire && cfg.hotkeys_enabled && active_d;

  // reset button edge loads the default value first, then up, then down
  assign rst_edge = in_q.reset_pressed && !reset_prev_q;
  assign val_rst  = rst_edge ? cfg.default_value : target_q;

  hra_btn u_btn_up (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (run),
    .upward_i  (1'b1),
    .pressed_i (in_q.up_pressed),
    .now_ms_i  (in_q.now_ms),
    .cfg_i     (cfg),
    .value_i   (val_rst),
    .value_o   (val_up),
    .release_o (rel_up)
  );

  hra_btn u_btn_dn (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (run),
    .upward_i  (1'b0),
    .pressed_i (in_q.down_pressed),
    .now_ms_i  (in_q.now_ms),
    .cfg_i     (cfg),
    .value_i   (val_up),
    .value_o   (val_dn),
    .release_o (rel_dn)
  );

  assign target_d = run ? val_dn : target_q;
  // save pulses on a reset edge or a step button release
  assign save     = run && (rst_edge || rel_up || rel_dn);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b1;
      toggle_prev_q <= 1'b0;
      reset_prev_q  <= 1'b0;
      target_q      <= RstDefault;
    end else if (fire && cfg.hotkeys_enabled) begin
      active_q      <= active_d;
      toggle_prev_q <= in_q.toggle_pressed;
      // reset edge detector freezes while inactive
      if (active_d) begin
        reset_prev_q <= in_q.reset_pressed;
        target_q     <= target_d;
      end
    end
  end

  // ---------------- result register ----------------
  logic     out_valid_q;
  out_rsp_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.value_out   <= target_d;
      out_q.active      <= active_d;
      out_q.save_strobe <= save;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

/* sv/hra_checker.sv */
// hra_checker: port-level assertions for the adjuster top level, attached by bind
// depends on hra_pkg and hold_repeat_value_adjuster_top
`timescale 1ns / 1ps

module hra_checker import hra_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_rsp_t out_rsp_o
);

  // a stalled result stays valid
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_rsp_o))
    else $error("result changed while stalled");

  // requests back up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled with free result register");

  // save strobe only when the adjuster is active
  a_save_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.save_strobe |-> out_rsp_o.active)
    else $error("save strobe while inactive");

endmodule

bind hold_repeat_value_adjuster_top hra_checker u_hra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
